/* hdl/svd_pkg.sv */
// shared constants for the sine wave vertex deformer
package svd_pkg;

	localparam int unsigned DIV_STEPS = 56;
	localparam int unsigned LANE_LAT = DIV_STEPS + 10;

	localparam logic [2:0] CFG_MODE = 3'd0;
	localparam logic [2:0] CFG_PHASE = 3'd1;
	localparam logic [2:0] CFG_AMP = 3'd2;
	localparam logic [2:0] CFG_WAVES = 3'd3;
	localparam logic [2:0] CFG_WIDTH = 3'd4;
	localparam logic [2:0] CFG_HEIGHT = 3'd5;

	localparam logic [2:0] MODE_PASS = 3'd0;
	localparam logic [2:0] MODE_HORIZ = 3'd1;
	localparam logic [2:0] MODE_VERT = 3'd2;
	localparam logic [2:0] MODE_BOTH = 3'd3;
	localparam logic [2:0] MODE_LIQUID = 3'd4;

	localparam logic [15:0] SIN_A = 16'd51472;
	localparam logic [14:0] SIN_B = 15'd21024;
	localparam logic [11:0] SIN_C = 12'd2320;
	localparam logic [16:0] LIQUID_Q16 = 17'd85852;
	localparam logic [15:0] WAVES_RESET = 16'd256;

endpackage

/* hdl/svd_lane.sv */
// one displacement lane: wave position divider, sine, scale and saturate
module svd_lane (
	input  logic               clk,
	input  logic signed [31:0] coord,
	input  logic signed [31:0] base,
	input  logic [30:0]        size,
	input  logic [15:0]        phase,
	input  logic [15:0]        waves,
	input  logic signed [31:0] amp,
	input  logic               en,
	output logic signed [31:0] result
);

	localparam int unsigned N = svd_pkg::DIV_STEPS;
	localparam logic [11:0] SIN_C_W = svd_pkg::SIN_C;

	logic [31:0]        mag_s1;
	logic               neg_s1;
	logic signed [31:0] base_s1;

	logic [30:0]        rem_sd  [0:N];
	logic [N-1:0]       dvd_sd  [0:N];
	logic [15:0]        quo_sd  [0:N];
	logic               neg_sd  [0:N];
	logic signed [31:0] base_sd [0:N];

	logic [15:0]        angle_s3;
	logic signed [31:0] base_s3;
	logic [1:0]         quad_s4;
	logic [15:0]        z_s4;
	logic signed [31:0] base_s4;
	logic [1:0]         quad_s5;
	logic [15:0]        z_s5;
	logic [15:0]        z2_s5;
	logic signed [31:0] base_s5;
	logic [1:0]         quad_s6;
	logic [15:0]        z_s6;
	logic [15:0]        z2_s6;
	logic [14:0]        t2_s6;
	logic signed [31:0] base_s6;
	logic [1:0]         quad_s7;
	logic [15:0]        z_s7;
	logic [15:0]        t4_s7;
	logic signed [31:0] base_s7;
	logic signed [16:0] sin_s8;
	logic signed [31:0] base_s8;
	logic signed [48:0] prod_s9;
	logic signed [31:0] base_s9;

	logic [47:0]        prod_w;
	logic [15:0]        qsel;
	logic [31:0]        zz;
	logic [26:0]        t1p;
	logic [30:0]        t3p;
	logic [31:0]        sp;
	logic [15:0]        s_mag;
	logic signed [49:0] rnd;
	logic signed [33:0] sum;

	assign prod_w = mag_s1 * waves;

	always_ff @(posedge clk) begin
		mag_s1 <= coord[31] ? 32'(-coord) : 32'(coord);
		neg_s1 <= coord[31];
		base_s1 <= base;
		rem_sd[0] <= '0;
		dvd_sd[0] <= {prod_w, 8'b0};
		quo_sd[0] <= '0;
		neg_sd[0] <= neg_s1;
		base_sd[0] <= base_s1;
	end

	for (genvar k = 0; k < N; k++) begin : g_div
		logic [31:0] trial;
		logic [31:0] diff;
		logic        fits;
		assign trial = {rem_sd[k], dvd_sd[k][N-1]};
		assign diff = trial - {1'b0, size};
		assign fits = trial >= {1'b0, size};
		always_ff @(posedge clk) begin
			rem_sd[k+1] <= fits ? diff[30:0] : trial[30:0];
			dvd_sd[k+1] <= {dvd_sd[k][N-2:0], 1'b0};
			quo_sd[k+1] <= {quo_sd[k][14:0], fits};
			neg_sd[k+1] <= neg_sd[k];
			base_sd[k+1] <= base_sd[k];
		end
	end

	always_comb begin
		if (size == '0) begin
			qsel = '0;
		end else if (neg_sd[N]) begin
			qsel = 16'(-quo_sd[N]);
		end else begin
			qsel = quo_sd[N];
		end
	end

	assign zz = z_s4 * z_s4;
	assign t1p = SIN_C_W * z2_s5;
	assign t3p = t2_s6 * z2_s6;
	assign sp = t4_s7 * z_s7;
	assign s_mag = (sp[31:15] > 17'd32767) ? 16'd32767 : sp[30:15];
	assign rnd = 50'(prod_s9) + 50'sd16384;
	assign sum = 34'(base_s9) + $signed(rnd[48:15]);

	always_ff @(posedge clk) begin
		angle_s3 <= qsel + phase;
		base_s3 <= base_sd[N];

		quad_s4 <= angle_s3[15:14];
		z_s4 <= angle_s3[14] ? 16'((16'd16384 - {2'b0, angle_s3[13:0]}) << 1)
			: {1'b0, angle_s3[13:0], 1'b0};
		base_s4 <= base_s3;

		quad_s5 <= quad_s4;
		z_s5 <= z_s4;
		z2_s5 <= zz[30:15];
		base_s5 <= base_s4;

		quad_s6 <= quad_s5;
		z_s6 <= z_s5;
		z2_s6 <= z2_s5;
		t2_s6 <= svd_pkg::SIN_B - {3'b0, t1p[26:15]};
		base_s6 <= base_s5;

		quad_s7 <= quad_s6;
		z_s7 <= z_s6;
		t4_s7 <= svd_pkg::SIN_A - t3p[30:15];
		base_s7 <= base_s6;

		sin_s8 <= quad_s7[1] ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
		base_s8 <= base_s7;

		prod_s9 <= amp * sin_s8;
		base_s9 <= base_s8;

		if (!en) begin
			result <= base_s9;
		end else if (sum > 34'sh0_7FFF_FFFF) begin
			result <= 32'sh7FFF_FFFF;
		end else if (sum < -34'sh0_8000_0000) begin
			result <= -32'sh8000_0000;
		end else begin
			result <= sum[31:0];
		end
	end

endmodule

/* hdl/sine_wave_vertex_deformer_top.sv */
// top level of the sine wave vertex deformer: config registers and two lanes
//
// channel  | handshake    | payload
// ---------+--------------+-------------------------------------
// input    | start, busy  | orig_x, orig_y, orig_z
// result   | done         | moved_x, moved_y, moved_z
// config   | cfg_we       | cfg_idx, cfg_data
//
// one vertex per cycle; most of the pipeline from a transaction to its result
// is made up of the 56 one-bit steps of the wave position divider.
// busy stays low: the pipeline never holds, results cannot be stalled.
// arst_n clears the valid pipe and the config registers to their defaults.
module sine_wave_vertex_deformer_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] orig_x,
	input  logic signed [31:0] orig_y,
	input  logic signed [31:0] orig_z,
	output logic               done,
	output logic signed [31:0] moved_x,
	output logic signed [31:0] moved_y,
	output logic signed [31:0] moved_z,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [31:0]        cfg_data
);

	localparam int unsigned LAT = svd_pkg::LANE_LAT;

	logic [2:0]         mode_q;
	logic [15:0]        phase_q;
	logic signed [31:0] amp_q;
	logic [15:0]        waves_q;
	logic [30:0]        width_q;
	logic [30:0]        height_q;
	logic [15:0]        yphase_q;
	logic               horiz_q;
	logic               vert_q;
	logic [LAT-1:0]     vld_q;
	logic signed [31:0] zdly_q [0:LAT-1];
	logic [33:0]        liq;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= svd_pkg::MODE_PASS;
			phase_q <= '0;
			amp_q <= '0;
			waves_q <= svd_pkg::WAVES_RESET;
			width_q <= '0;
			height_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				svd_pkg::CFG_MODE: mode_q <= cfg_data[2:0];
				svd_pkg::CFG_PHASE: phase_q <= cfg_data[15:0];
				svd_pkg::CFG_AMP: amp_q <= cfg_data;
				svd_pkg::CFG_WAVES: waves_q <= cfg_data[15:0];
				svd_pkg::CFG_WIDTH: width_q <= cfg_data[30:0];
				svd_pkg::CFG_HEIGHT: height_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	assign liq = 34'(phase_q * svd_pkg::LIQUID_Q16) + 34'd32768;

	always_ff @(posedge clk) begin
		yphase_q <= (mode_q == svd_pkg::MODE_LIQUID) ? liq[31:16] : phase_q;
		horiz_q <= (mode_q == svd_pkg::MODE_HORIZ) || (mode_q == svd_pkg::MODE_BOTH)
			|| (mode_q == svd_pkg::MODE_LIQUID);
		vert_q <= (mode_q == svd_pkg::MODE_VERT) || (mode_q == svd_pkg::MODE_BOTH)
			|| (mode_q == svd_pkg::MODE_LIQUID);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start};
		end
	end

	always_ff @(posedge clk) begin
		zdly_q[0] <= orig_z;
		for (int i = 1; i < LAT; i++) begin
			zdly_q[i] <= zdly_q[i-1];
		end
	end

	svd_lane u_horiz (
		.clk    (clk),
		.coord  (orig_y),
		.base   (orig_x),
		.size   (height_q),
		.phase  (phase_q),
		.waves  (waves_q),
		.amp    (amp_q),
		.en     (horiz_q),
		.result (moved_x)
	);

	svd_lane u_vert (
		.clk    (clk),
		.coord  (orig_x),
		.base   (orig_y),
		.size   (width_q),
		.phase  (yphase_q),
		.waves  (waves_q),
		.amp    (amp_q),
		.en     (vert_q),
		.result (moved_y)
	);

	assign done = vld_q[LAT-1];
	assign moved_z = zdly_q[LAT-1];

`ifndef SYNTH
	a_z_through: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> moved_z == $past(orig_z, LAT))
		else $error("z changed on its way through");
	a_pass_x: assert property (@(posedge clk) disable iff (!arst_n)
		(done && mode_q == svd_pkg::MODE_PASS) |-> moved_x == $past(orig_x, LAT))
		else $error("x moved in pass-through");
	a_pass_y: assert property (@(posedge clk) disable iff (!arst_n)
		(done && mode_q == svd_pkg::MODE_HORIZ) |-> moved_y == $past(orig_y, LAT))
		else $error("y moved in horizontal mode");
`endif

endmodule
